// ===== hdl/ts_pkg.sv =====
// Package for the triangular solver: sizes, sequencer states, helpers.
// No dependencies.
package ts_pkg;
    localparam int MAX_DIM_DEF     = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int ACC_W           = 64;

    localparam logic CFG_DIMENSION = 1'b0;
    localparam logic CFG_UPPER     = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ELEM,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_NUM,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

// ===== hdl/ts_div.sv =====
// Restoring divider, one quotient bit a cycle: 64-bit magnitude over 32-bit magnitude.
// Depends on ts_pkg.
module ts_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       num_mag,
    input  logic [31:0]       den_mag,
    output ts_pkg::div_ctl_t  ctl,
    output logic [63:0]       quo
);
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb begin
        trial    = {rem_reg[31:0], quo_reg[63]};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        quo_next = {quo_reg[62:0], 1'b0};
        rem_next = trial;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = num_mag;
            rem_next = '0;
            cnt_next = 7'd64;
        end else if (cnt_reg != 7'd0) begin
            cnt_next = cnt_reg - 7'd1;
            if (!diff[33]) begin
                rem_next    = diff[32:0];
                quo_next[0] = 1'b1;
            end
        end else begin
            quo_next = quo_reg;
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den_mag;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = (cnt_reg != 7'd0);
    assign quo       = quo_reg;

    ap_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.busy |-> !start) else $error("divider restarted while busy");
    ap_load: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> cnt_reg == 7'd64) else $error("divider count not loaded");
    ap_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 7'd1) |=> !ctl.busy) else $error("divider did not finish");
endmodule

// ===== hdl/triangular_solve.sv =====
// Triangular solver top level: load stores, multiply-accumulate sequencer.
// Depends on ts_pkg and ts_div.
// s_ready is high while loading.
// After the final beat, each element k takes a read, multiply and add per
// off-diagonal term on one shared multiplier, a numerator step, the
// bit-serial divider (start, the 64-bit quotient, hand-off), then saturate
// and step on; the saturate step waits while m_ready stalls the output.
// Results leave through one output register.
// Synchronous active-low reset returns the sequencer to load, clears m_valid and the
// accumulator, and sets dimension 16, lower; stores are not cleared.
module triangular_solve #(
    parameter int MAX_DIM     = ts_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = ts_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [3:0]  s_row,
    input  logic [3:0]  s_column,
    input  logic signed [31:0] s_value,
    input  logic        s_final_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_index,
    output logic signed [31:0] m_solution,
    output logic        m_zero_pivot,
    output logic        m_overflow,
    output logic        m_last
);
    localparam int SW      = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LIM     = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam logic signed [63:0] AMAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] AMIN = {1'b1, 63'd0};

    logic signed [SW-1:0] coef_mem [DEPTH];
    logic signed [SW-1:0] rhs_mem  [MAX_DIM];
    logic signed [SW-1:0] sol_mem  [MAX_DIM];

    ts_pkg::state_t st_reg, st_next;
    logic [4:0]  dim_reg;
    logic        upper_reg;
    logic [4:0]  n_reg;
    logic [4:0]  s_reg;
    logic [4:0]  k_reg;
    logic [4:0]  i_reg, hi_reg;
    logic signed [63:0] acc_reg;
    logic signed [SW-1:0] diag_reg, rhs_reg;
    logic signed [63:0] prod_reg;
    logic        ov_reg;
    logic        neg_reg;
    logic [63:0] nmag_reg;
    logic [31:0] dmag_reg;
    logic        div_start;
    logic [63:0] quo;
    ts_pkg::div_ctl_t dctl;

    logic        ov_q_reg;
    logic [3:0]  idx_q_reg;
    logic signed [31:0] sol_q_reg;
    logic        zp_q_reg, last_q_reg, valid_q_reg;

    logic        in_acc;
    logic signed [SW-1:0] in_val;
    logic [4:0]  n_eff;
    logic [4:0]  k_first;

    assign s_ready   = (st_reg == ts_pkg::ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;

    always_comb begin
        if (s_value > 32'(VMAX)) begin
            in_val = SW'(VMAX);
        end else if (s_value < 32'(VMIN)) begin
            in_val = SW'(VMIN);
        end else begin
            in_val = SW'(s_value);
        end
        n_eff = dim_reg;
        if (n_eff == 5'd0) begin
            n_eff = 5'd1;
        end
        if (n_eff > 5'(LIM)) begin
            n_eff = 5'(LIM);
        end
        k_first = upper_reg ? n_eff - 5'd1 : 5'd0;
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (!s_mode) begin
                if (32'(s_row) < MAX_DIM && 32'(s_column) < MAX_DIM) begin
                    coef_mem[(2*IW)'(s_row) * (2*IW)'(MAX_DIM) + (2*IW)'(s_column)] <= in_val;
                end
            end else if (32'(s_row) < MAX_DIM) begin
                rhs_mem[IW'(s_row)] <= in_val;
            end
        end
    end

    // registered read port for coefficient and solution terms, addressed by the sequencer
    logic [2*IW-1:0] rd_addr;
    logic signed [SW-1:0] coef_rd;
    logic signed [SW-1:0] sol_rd;
    always_comb begin
        rd_addr = IW'(k_reg) * (2*IW)'(MAX_DIM) + (2*IW)'(IW'(i_reg));
    end
    always_ff @(posedge aclk) begin
        coef_rd <= coef_mem[rd_addr];
        sol_rd  <= sol_mem[IW'(i_reg)];
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ts_pkg::ST_LOAD: if (in_acc && s_final_req) st_next = ts_pkg::ST_ELEM;
            ts_pkg::ST_ELEM: st_next = ts_pkg::ST_RD;
            ts_pkg::ST_RD:   st_next = (i_reg == hi_reg) ? ts_pkg::ST_NUM : ts_pkg::ST_MUL;
            ts_pkg::ST_MUL:  st_next = ts_pkg::ST_ACC;
            ts_pkg::ST_ACC:  st_next = ts_pkg::ST_RD;
            ts_pkg::ST_NUM:  st_next = ts_pkg::ST_DIV;
            ts_pkg::ST_DIV:  if (!dctl.busy && !dctl.start) st_next = ts_pkg::ST_SAT;
            ts_pkg::ST_SAT:  if (!valid_q_reg || m_ready) st_next = ts_pkg::ST_OUT;
            ts_pkg::ST_OUT:  st_next = (s_reg == n_reg) ? ts_pkg::ST_LOAD : ts_pkg::ST_ELEM;
            default:         st_next = ts_pkg::ST_LOAD;
        endcase
    end

    logic signed [64:0] sum_w;
    logic signed [64:0] num_w;
    logic signed [63:0] rhs_sh;
    logic signed [63:0] negacc;
    logic signed [63:0] num_sat;
    logic               num_ov;
    logic signed [63:0] x_w;
    logic               x_ov;
    logic               zp_w;
    always_comb begin
        sum_w  = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
        rhs_sh = 64'(rhs_reg) <<< ts_pkg::FRAC_BITS;
        negacc = (acc_reg == AMIN) ? AMAX : -acc_reg;
        num_w  = {rhs_sh[63], rhs_sh} + {negacc[63], negacc};
        num_ov = (acc_reg == AMIN);
        num_sat = num_w[63:0];
        if (num_w[64] != num_w[63]) begin
            num_ov  = 1'b1;
            num_sat = num_w[64] ? AMIN : AMAX;
        end
        zp_w = (diag_reg == '0);
        x_ov = 1'b0;
        if (!neg_reg) begin
            if (quo > 64'(VMAX)) begin
                x_w = VMAX; x_ov = 1'b1;
            end else begin
                x_w = $signed(quo);
            end
        end else if (quo > 64'(VMAX) + 64'd1) begin
            x_w = VMIN; x_ov = 1'b1;
        end else begin
            x_w = -$signed(quo);
        end
        if (zp_w) begin
            x_w = '0;
        end
    end

    assign div_start = (st_reg == ts_pkg::ST_NUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ts_pkg::ST_LOAD;
            dim_reg     <= 5'd16;
            upper_reg   <= 1'b0;
            valid_q_reg <= 1'b0;
            acc_reg     <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ts_pkg::CFG_DIMENSION: dim_reg   <= cfg_data[4:0];
                    ts_pkg::CFG_UPPER:     upper_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (st_reg == ts_pkg::ST_SAT && (!valid_q_reg || m_ready)) begin
                valid_q_reg <= 1'b1;
            end else if (valid_q_reg && m_ready) begin
                valid_q_reg <= 1'b0;
            end
            case (st_reg)
                ts_pkg::ST_LOAD: begin
                    n_reg <= n_eff;
                    s_reg <= 5'd0;
                    k_reg <= k_first;
                end
                ts_pkg::ST_ELEM: begin
                    acc_reg  <= '0;
                    ov_reg   <= 1'b0;
                    i_reg    <= upper_reg ? k_reg + 5'd1 : 5'd0;
                    hi_reg   <= upper_reg ? n_reg : k_reg;
                    diag_reg <= coef_mem[IW'(k_reg) * (2*IW)'(MAX_DIM) + (2*IW)'(IW'(k_reg))];
                    rhs_reg  <= rhs_mem[IW'(k_reg)];
                end
                // coef_rd and sol_rd hold the term addressed in ST_RD
                ts_pkg::ST_MUL: prod_reg <= 64'(coef_rd) * 64'(sol_rd);
                ts_pkg::ST_ACC: begin
                    i_reg <= i_reg + 5'd1;
                    if (sum_w[64] != sum_w[63]) begin
                        acc_reg <= sum_w[64] ? AMIN : AMAX;
                        ov_reg  <= 1'b1;
                    end else begin
                        acc_reg <= sum_w[63:0];
                    end
                end
                ts_pkg::ST_NUM: begin
                    ov_reg   <= ov_reg | num_ov;
                    neg_reg  <= num_sat[63] != diag_reg[SW-1];
                    nmag_reg <= num_sat[63] ? 64'(0) - 64'(num_sat) : 64'(num_sat);
                    dmag_reg <= diag_reg[SW-1] ? 32'(-64'(diag_reg)) : 32'(diag_reg);
                end
                ts_pkg::ST_SAT: if (!valid_q_reg || m_ready) begin
                    idx_q_reg   <= k_reg[3:0];
                    sol_q_reg   <= 32'(x_w);
                    zp_q_reg    <= zp_w;
                    ov_q_reg    <= zp_w ? 1'b0 : (ov_reg | x_ov);
                    last_q_reg  <= (s_reg + 5'd1 == n_reg);
                    sol_mem[IW'(k_reg)] <= SW'(x_w);
                    s_reg       <= s_reg + 5'd1;
                end
                ts_pkg::ST_OUT: k_reg <= upper_reg ? k_reg - 5'd1 : k_reg + 5'd1;
                default: ;
            endcase
        end
    end

    // nmag is loaded in ST_NUM, so the divider start pulse is registered and arrives in the cycle after ST_NUM
    logic start_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_d_reg <= 1'b0;
        end else begin
            start_d_reg <= div_start;
        end
    end

    ts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_d_reg),
        .num_mag (nmag_reg),
        .den_mag ((dmag_reg == 32'd0) ? 32'd1 : dmag_reg),
        .ctl     (dctl),
        .quo     (quo)
    );

    assign m_valid      = valid_q_reg;
    assign m_index      = idx_q_reg;
    assign m_solution   = sol_q_reg;
    assign m_zero_pivot = zp_q_reg;
    assign m_overflow   = ov_q_reg;
    assign m_last       = last_q_reg;

    ap_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ts_pkg::ST_LOAD) |-> !s_ready) else $error("ready while solving");
    ap_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_zero_pivot && m_overflow)) else $error("both flags set");
    ap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_pivot) |-> m_solution == 32'd0) else $error("zero pivot value");
    ap_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_final_req) |=> st_reg == ts_pkg::ST_ELEM) else $error("solve not started");
endmodule
